// ===== sv/c3f_pkg.sv =====
`default_nettype none
package c3f_pkg;

    // Largest image row that the line buffers hold.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;
    localparam int X_W     = $clog2(MAX_WIDTH);
    localparam int COLC_W  = X_W + 1;
    localparam int ROW_W   = 12;
    localparam int WREG_W  = 11;
    localparam int HREG_W  = 13;
    localparam int TAPS_W  = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = 2 * PIX_W + 1;
    localparam int SUM_W   = PROD_W + 4;
    localparam int NTAPS   = 9;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_TAPS_TOP     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TAPS_MIDDLE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TAPS_BOTTOM  = 3'd4;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [TAPS_W-1:0] TAPS_TOP_RESET    = 24'd65793;
    localparam logic [TAPS_W-1:0] TAPS_MIDDLE_RESET = 24'd129025;
    localparam logic [TAPS_W-1:0] TAPS_BOTTOM_RESET = 24'd65793;

    typedef struct packed {
        logic              interior;
        logic [ROW_W-1:0]  orow;
        logic [X_W-1:0]    ocol;
        logic              last;
    } t_meta;

    typedef struct packed {
        logic [X_W-1:0] x;
        t_meta          meta;
    } t_coord;

    typedef logic signed [PROD_W-1:0] t_prod;

    // Signed tap k (0 left, 1 center, 2 right) of one kernel row.
    function automatic logic signed [PIX_W-1:0] tap_at(input logic [TAPS_W-1:0] row_bits,
                                                       input int k);
        tap_at = $signed(row_bits[k*PIX_W +: PIX_W]);
    endfunction

    function automatic t_prod tap_mul(input logic signed [PIX_W-1:0] tap,
                                      input logic [PIX_W-1:0] px);
        tap_mul = PROD_W'(tap) * PROD_W'($signed({1'b0, px}));
    endfunction

endpackage
`default_nettype wire

// ===== sv/c3f_pix_if.sv =====
`default_nettype none
interface c3f_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface
`default_nettype wire

// ===== sv/c3f_res_if.sv =====
`default_nettype none
interface c3f_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  value;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_last;

    modport source (output valid, output value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input frame_last, output ready);
endinterface
`default_nettype wire

// ===== sv/c3f_ram.sv =====
`default_nettype none
module c3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/c3f_coord.sv =====
`default_nettype none
module c3f_coord
    import c3f_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_frame_start,
    input  wire logic [WREG_W-1:0] i_width,
    input  wire logic [HREG_W-1:0] i_height,
    output t_coord                 o_coord
);
    logic [ROW_W-1:0]  r_row;
    logic [COLC_W-1:0] r_col;
    logic [WREG_W-1:0] w;
    logic [HREG_W-1:0] h;
    logic [WREG_W-1:0] w_m1;
    logic [HREG_W-1:0] h_m1;
    logic [COLC_W-1:0] col_s;
    logic [HREG_W-1:0] row_s;
    logic [ROW_W-1:0]  y;
    logic [X_W-1:0]    x;

    always_comb begin
        if (i_width < WREG_W'(3)) begin
            w = WREG_W'(3);
        end else if (i_width > WREG_W'(MAX_WIDTH)) begin
            w = WREG_W'(MAX_WIDTH);
        end else begin
            w = i_width;
        end
        if (i_height < HREG_W'(3)) begin
            h = HREG_W'(3);
        end else if (i_height > HREG_W'(MAX_HEIGHT)) begin
            h = HREG_W'(MAX_HEIGHT);
        end else begin
            h = i_height;
        end
        w_m1 = w - WREG_W'(1);
        h_m1 = h - HREG_W'(1);

        col_s = i_frame_start ? '0 : r_col;
        row_s = i_frame_start ? '0 : {1'b0, r_row};
        if (WREG_W'(col_s) >= w) begin
            col_s = '0;
            row_s = row_s + HREG_W'(1);
        end
        if (row_s >= h) begin
            row_s = '0;
        end
        y = row_s[ROW_W-1:0];
        x = col_s[X_W-1:0];

        o_coord.x             = x;
        o_coord.meta.interior = (y >= ROW_W'(2)) && (x >= X_W'(2));
        o_coord.meta.orow     = (y == '0) ? h_m1[ROW_W-1:0] : y - ROW_W'(1);
        o_coord.meta.ocol     = (x == '0) ? w_m1[X_W-1:0] : x - X_W'(1);
        o_coord.meta.last     = ({1'b0, y} == h_m1) && (WREG_W'(x) == w_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= y;
            r_col <= {1'b0, x} + COLC_W'(1);
        end
    end
endmodule
`default_nettype wire

// ===== sv/c3f_sum.sv =====
`default_nettype none
module c3f_sum
    import c3f_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_prod     i_prod [NTAPS],
    input  wire t_meta     i_meta,
    output logic           o_take,
    c3f_res_if.source      o_res
);
    logic                    r_valid;
    logic [PIX_W-1:0]        r_value;
    t_meta                   r_meta;
    logic signed [SUM_W-1:0] sum;
    logic [PIX_W-1:0]        n_value;

    assign o_take = !r_valid || o_res.ready;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NTAPS; i++) begin
            sum = sum + SUM_W'(i_prod[i]);
        end
        if (!i_meta.interior || sum < SUM_W'(0)) begin
            n_value = '0;
        end else if (sum > SUM_W'(255)) begin
            n_value = 8'hFF;
        end else begin
            n_value = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_value <= n_value;
            r_meta  <= i_meta;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.value      = r_value;
    assign o_res.out_row    = r_meta.orow;
    assign o_res.out_col    = r_meta.ocol;
    assign o_res.frame_last = r_meta.last;
endmodule
`default_nettype wire

// ===== sv/conv3x3_image_filter_core.sv =====
`default_nettype none
// Channel   Dir  Payload                                   Beat when
// i_pix     in   pixel[7:0], frame_start                   valid && ready
// o_res     out  value[7:0], out_row[11:0], out_col[9:0],  valid && ready
//                frame_last
// i_cfg     in   i_cfg_index[2:0], i_cfg_data[23:0]        i_cfg_we
//
// One pixel beat is taken every clock unless o_res stalls; each gives exactly one result beat.
// A pixel passes through the line-buffer read, the product register and the output register.
// The rate is set by the single read and write port of each line-buffer RAM.
// Reset is synchronous and active low; the line buffers are not cleared.
// Stages collapse bubbles, so a stalled output only blocks input once full.
module conv3x3_image_filter_core
    import c3f_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    c3f_pix_if.sink               i_pix,
    c3f_res_if.source             o_res,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    // Configuration registers; the user must write them only while the pipeline is empty, unchecked by the block.
    logic [WREG_W-1:0] r_width;
    logic [HREG_W-1:0] r_height;
    logic [TAPS_W-1:0] r_taps [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_taps[0] <= TAPS_TOP_RESET;
            r_taps[1] <= TAPS_MIDDLE_RESET;
            r_taps[2] <= TAPS_BOTTOM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width   <= i_cfg_data[WREG_W-1:0];
                REG_IMAGE_HEIGHT: r_height  <= i_cfg_data[HREG_W-1:0];
                REG_TAPS_TOP:     r_taps[0] <= i_cfg_data[TAPS_W-1:0];
                REG_TAPS_MIDDLE:  r_taps[1] <= i_cfg_data[TAPS_W-1:0];
                REG_TAPS_BOTTOM:  r_taps[2] <= i_cfg_data[TAPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshakes. Each stage loads when it is empty or its content moves on.
    logic out_take;
    logic s2_take;
    logic s1_take;
    logic accept;
    logic s1_move;

    logic r_s1_v;
    logic r_s2_v;

    assign s2_take = !r_s2_v || out_take;
    assign s1_take = !r_s1_v || s2_take;
    assign accept  = i_pix.valid && s1_take;
    assign s1_move = r_s1_v && s2_take;
    assign i_pix.ready = s1_take;

    // Coordinates of the incoming pixel.
    t_coord coord;

    c3f_coord u_coord (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_pix.frame_start),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_coord       (coord)
    );

    // Stage 1: the line buffers are read at the new column as the pixel is taken.
    // They are written with the shifted column when the pixel leaves stage 1.
    logic [PIX_W-1:0] r_s1_px;
    t_coord           r_s1_coord;
    logic             r_s1_fwd;
    logic [PIX_W-1:0] r_s1_fwd_top;
    logic [PIX_W-1:0] r_s1_fwd_mid;
    logic [PIX_W-1:0] top_q;
    logic [PIX_W-1:0] mid_q;
    logic [PIX_W-1:0] s1_top;
    logic [PIX_W-1:0] s1_mid;

    assign s1_top = r_s1_fwd ? r_s1_fwd_top : top_q;
    assign s1_mid = r_s1_fwd ? r_s1_fwd_mid : mid_q;

    // Row y-1 of the line store.
    c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_coord.x),
        .i_wdata (r_s1_px),
        .i_re    (accept),
        .i_raddr (coord.x),
        .o_rdata (mid_q)
    );

    // Row y-2 of the line store.
    c3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_coord.x),
        .i_wdata (s1_mid),
        .i_re    (accept),
        .i_raddr (coord.x),
        .o_rdata (top_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_take) begin
            r_s1_v <= i_pix.valid;
        end
    end

    // When the same column is read while stage 1 writes it (a repeated frame
    // start), the RAM returns stale data, so the values being written are kept.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px      <= i_pix.pixel;
            r_s1_coord   <= coord;
            r_s1_fwd     <= s1_move && (r_s1_coord.x == coord.x);
            r_s1_fwd_top <= s1_mid;
            r_s1_fwd_mid <= r_s1_px;
        end
    end

    // Window of the two previous columns: entries 0..2 are the left column
    // (top, middle, bottom), entries 3..5 the center column.
    logic [PIX_W-1:0] r_win [6];
    logic [PIX_W-1:0] new_col [3];

    assign new_col[0] = s1_top;
    assign new_col[1] = s1_mid;
    assign new_col[2] = r_s1_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_move) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r]     <= r_win[3 + r];
                r_win[3 + r] <= new_col[r];
            end
        end
    end

    // Nine tap products, registered into stage 2.
    t_prod prod [NTAPS];
    t_prod r_s2_prod [NTAPS];
    t_meta r_s2_meta;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            prod[3*r]     = tap_mul(tap_at(r_taps[r], 0), r_win[r]);
            prod[3*r + 1] = tap_mul(tap_at(r_taps[r], 1), r_win[3 + r]);
            prod[3*r + 2] = tap_mul(tap_at(r_taps[r], 2), new_col[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_take) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_prod <= prod;
            r_s2_meta <= r_s1_coord.meta;
        end
    end

    // Stage 3: sum, saturation, border zeroing and the output register.
    c3f_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .i_prod  (r_s2_prod),
        .i_meta  (r_s2_meta),
        .o_take  (out_take),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire
